@@ rtl/xbr_pkg.sv @@
// ----------------------------------------------------------------------------
// xbr_pkg
// shared constants and types for the bounded xorshift random source
// ----------------------------------------------------------------------------
`default_nettype none

package xbr_pkg;

  localparam int GEN_W = 32;
  localparam int OUT_W = 8;
  localparam int CNT_W = 4;

  localparam int SHIFT_A = 13;
  localparam int SHIFT_B = 17;
  localparam int SHIFT_C = 5;

  localparam logic [GEN_W-1:0] GEN_ONES = 32'hFFFF_FFFF;

  localparam logic [1:0] OP_RESEED    = 2'd0;
  localparam logic [1:0] OP_GET_BITS  = 2'd1;
  localparam logic [1:0] OP_GET_VALUE = 2'd2;

  typedef struct packed {
    logic             load;
    logic             step;
    logic [GEN_W-1:0] seed;
  } gen_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/xbr_if.sv @@
// ----------------------------------------------------------------------------
// xbr_req_if / xbr_rsp_if
// valid/ready channels for requests and results
// ----------------------------------------------------------------------------
`default_nettype none

interface xbr_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] seed_value;
  logic [3:0]  bit_count;
  logic [7:0]  min_bound;
  logic [7:0]  max_bound;

  modport source (output valid, output opcode, output seed_value, output bit_count,
                  output min_bound, output max_bound, input ready);
  modport sink (input valid, input opcode, input seed_value, input bit_count,
                input min_bound, input max_bound, output ready);
endinterface

interface xbr_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] random_out;

  modport source (output valid, output random_out, input ready);
  modport sink (input valid, input random_out, output ready);
endinterface

`default_nettype wire

@@ rtl/xbr_gen.sv @@
// ----------------------------------------------------------------------------
// xbr_gen
// generator register with the single shared xorshift step unit
// ----------------------------------------------------------------------------
`default_nettype none

module xbr_gen
  import xbr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire gen_ctrl_t ctrl,
  output logic           step_bit
);

  logic [GEN_W-1:0] generator;
  logic [GEN_W-1:0] generator_next;
  logic [GEN_W-1:0] s1;
  logic [GEN_W-1:0] s2;
  logic [GEN_W-1:0] s3;

  always_comb begin
    s1 = generator ^ (generator << SHIFT_A);
    s2 = s1 ^ (s1 >> SHIFT_B);
    s3 = s2 ^ (s2 << SHIFT_C);
  end

  always_comb begin
    generator_next = generator;
    if (ctrl.load) begin
      generator_next = (ctrl.seed != '0) ? ctrl.seed : GEN_ONES;
    end else if (ctrl.step) begin
      generator_next = s3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      generator <= GEN_ONES;
    end else begin
      generator <= generator_next;
    end
  end

  assign step_bit = s3[0];

endmodule

`default_nettype wire

@@ rtl/xbr_seq.sv @@
// ----------------------------------------------------------------------------
// xbr_seq
// request sequencer: bit drawing, rejection check and result register
// ----------------------------------------------------------------------------
`default_nettype none

module xbr_seq
  import xbr_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  xbr_req_if.sink     req,
  xbr_rsp_if.source   rsp,
  output gen_ctrl_t   gen_ctrl,
  input  wire logic   step_bit
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DRAW = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [OUT_W-1:0] acc;
  logic [OUT_W-1:0] acc_next;
  logic [OUT_W-1:0] result;
  logic [OUT_W-1:0] result_next;
  logic             bounded;
  logic             bounded_next;
  logic [OUT_W-1:0] range;
  logic [OUT_W-1:0] range_next;
  logic [CNT_W-1:0] draw_len;
  logic [CNT_W-1:0] draw_len_next;
  logic [OUT_W-1:0] lo;
  logic [OUT_W-1:0] lo_next;

  logic             accept;
  logic [OUT_W-1:0] in_range;
  logic [CNT_W-1:0] in_len;
  logic [OUT_W-1:0] shifted;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign rsp.valid = (state == S_DONE);
  assign rsp.random_out = result;
  assign shifted   = {acc[OUT_W-2:0], step_bit};

  assign gen_ctrl.load = accept && (req.opcode == OP_RESEED);
  assign gen_ctrl.step = (state == S_DRAW);
  assign gen_ctrl.seed = req.seed_value;

  // bit length of the range (highest set bit position plus one)
  always_comb begin
    in_range = req.max_bound - req.min_bound;
    in_len   = '0;
    for (int i = 0; i < OUT_W; i++) begin
      if (in_range[i]) begin
        in_len = CNT_W'(i + 1);
      end
    end
  end

  always_comb begin
    state_next    = state;
    count_next    = count;
    acc_next      = acc;
    result_next   = result;
    bounded_next  = bounded;
    range_next    = range;
    draw_len_next = draw_len;
    lo_next       = lo;
    case (state)
      S_IDLE: begin
        if (accept) begin
          acc_next    = '0;
          result_next = '0;
          state_next  = S_DONE;
          case (req.opcode)
            OP_RESEED: begin
              result_next = '0;
            end
            OP_GET_BITS: begin
              bounded_next = 1'b0;
              count_next   = req.bit_count;
              if (req.bit_count != '0) begin
                state_next = S_DRAW;
              end
            end
            OP_GET_VALUE: begin
              if (req.max_bound <= req.min_bound) begin
                result_next = req.min_bound;
              end else begin
                bounded_next  = 1'b1;
                range_next    = in_range;
                draw_len_next = in_len;
                count_next    = in_len;
                lo_next       = req.min_bound;
                state_next    = S_DRAW;
              end
            end
            default: begin
              result_next = '0;
            end
          endcase
        end
      end
      S_DRAW: begin
        acc_next   = shifted;
        count_next = count - 1'b1;
        if (count == CNT_W'(1)) begin
          if (!bounded) begin
            result_next = shifted;
            state_next  = S_DONE;
          end else if (shifted <= range) begin
            result_next = shifted + lo;
            state_next  = S_DONE;
          end else begin
            // rejected draw, start over
            acc_next   = '0;
            count_next = draw_len;
          end
        end
      end
      S_DONE: begin
        if (rsp.ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    count    <= count_next;
    acc      <= acc_next;
    result   <= result_next;
    bounded  <= bounded_next;
    range    <= range_next;
    draw_len <= draw_len_next;
    lo       <= lo_next;
  end

endmodule

`default_nettype wire

@@ rtl/xorshift_bounded_random.sv @@
// ----------------------------------------------------------------------------
// xorshift_bounded_random
// bounded random source built on a 32-bit xorshift generator
// ----------------------------------------------------------------------------
// One request at a time, one result per request. The generator makes one
// xorshift step (13 left, 17 right, 5 left) per clock while drawing, in a
// single shared unit, so a get-bits request with N bits holds the block
// while it draws N bits, and a get-value request draws n bits per try,
// n being the bit length of max_bound - min_bound, repeated for each
// rejected draw (under two draws on average). Reseed, opcode 3, zero bit
// count and an empty bound skip drawing. Once ready, the result is
// shown until taken, and the next request is accepted the cycle after.
// After reset the generator holds all ones.
// ----------------------------------------------------------------------------
`default_nettype none

module xorshift_bounded_random
  import xbr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  xbr_req_if.sink   req,
  xbr_rsp_if.source rsp
);

  gen_ctrl_t gen_ctrl;
  logic      step_bit;

  xbr_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .rsp      (rsp),
    .gen_ctrl (gen_ctrl),
    .step_bit (step_bit)
  );

  xbr_gen u_gen (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (gen_ctrl),
    .step_bit (step_bit)
  );

endmodule

`default_nettype wire
